>>> hdl/ascii_hex_frame_receiver_defines.svh
// Assertion macros for the ASCII hex frame receiver checker.
// No dependencies; the including module must provide aclk and aresetn.
`ifndef ASCII_HEX_FRAME_RECEIVER_DEFINES_SVH
`define ASCII_HEX_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define AHFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define AHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ahfr_pkg.sv
// Shared types, constants and codes of the ASCII hex frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package ahfr_pkg;

    localparam int MAX_FRAME_CHARS = 64;
    localparam int POS_W           = 8;

    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd12;
    localparam logic [7:0] HEADER_CHARS   = 8'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic REC_PAYLOAD = 1'b0;
    localparam logic REC_END     = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_OTHER     = 3'd1;
    localparam logic [2:0] STATUS_CHECKSUM  = 3'd2;
    localparam logic [2:0] STATUS_LENGTH    = 3'd3;
    localparam logic [2:0] STATUS_BAD_DIGIT = 3'd4;

    // Header field slots, indexed by character position / 2.
    localparam logic [2:0] FLD_LENGTH = 3'd0;
    localparam logic [2:0] FLD_DEST   = 3'd1;
    localparam logic [2:0] FLD_SOURCE = 3'd2;
    localparam logic [2:0] FLD_PORT   = 3'd3;

    // Classified received word, as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       hex_ok;
        logic [3:0] nibble;
    } tag_t;

endpackage

>>> hdl/ahfr_queue.sv
// Short FIFO of classified words between the front and back ends.
// Depends on ahfr_pkg.
`timescale 1ns / 1ps

module ahfr_queue
    import ahfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tag_t push_tag,
    input  logic pop,
    output tag_t head_tag,
    output logic full,
    output logic empty
);

    tag_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_tag = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_tag;
        end
    end

endmodule

>>> hdl/ahfr_front.sv
// Front end: takes received words and classifies them (terminator, hex digit).
// Depends on ahfr_pkg.
`timescale 1ns / 1ps

module ahfr_front
    import ahfr_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       queue_full,
    output logic       push,
    output tag_t       push_tag
);

    // Returns {digit ok, nibble}; a non-digit decodes as nibble 0.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h37;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h57;
                return {1'b1, v[3:0]};
            end
            return 5'b0_0000;
        end
    endfunction

    logic [4:0] decoded;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;
    assign decoded = hex_decode(s_data_byte);

    always_comb begin
        push_tag.data   = s_data_byte;
        push_tag.is_cr  = (s_data_byte == CHAR_CR);
        push_tag.hex_ok = decoded[4];
        push_tag.nibble = decoded[3:0];
    end

endmodule

>>> hdl/ahfr_back.sv
// Back end: frame state, header decode, checksum and the result register.
// Depends on ahfr_pkg.
`timescale 1ns / 1ps

module ahfr_back
    import ahfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  tag_t       head_tag,
    input  logic       queue_empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_record_type,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_dest_address,
    output logic [7:0] m_source_address,
    output logic [7:0] m_port_number,
    output logic [7:0] m_command_code,
    output logic [2:0] m_frame_status
);

    logic [7:0]       dev_addr_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [3:0]       hn_reg, hn_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       dest_reg, dest_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       port_reg, port_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       sent_reg, sent_next;
    logic             derr_reg, derr_next;

    logic             valid_reg, valid_next;
    logic             type_reg, type_next;
    logic [7:0]       pay_reg, pay_next;
    logic [7:0]       olen_reg, olen_next;
    logic [7:0]       odest_reg, odest_next;
    logic [7:0]       osrc_reg, osrc_next;
    logic [7:0]       oport_reg, oport_next;
    logic [7:0]       ocmd_reg, ocmd_next;
    logic [2:0]       ostat_reg, ostat_next;

    // Working copy of the frame state a character is applied to.
    logic [POS_W-1:0] b_pos;
    logic [7:0]       b_sum, b_len, b_dest, b_src, b_port, b_cmd, b_sent;
    logic [3:0]       b_hn;
    logic             b_derr;
    logic [8:0]       p_plus1, p_plus2, len9;
    logic             valid_len, closing, payload;
    logic [7:0]       pair;
    logic [2:0]       status;

    assign pop = !queue_empty && (!valid_reg || m_ready);

    always_comb begin
        if (len_reg < FRAME_OVERHEAD || pos_reg != len_reg) begin
            status = STATUS_LENGTH;
        end else if (derr_reg) begin
            status = STATUS_BAD_DIGIT;
        end else if (dest_reg != dev_addr_reg) begin
            status = STATUS_OTHER;
        end else if (sum_reg != sent_reg) begin
            status = STATUS_CHECKSUM;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hn_next   = hn_reg;
        len_next  = len_reg;
        dest_next = dest_reg;
        src_next  = src_reg;
        port_next = port_reg;
        cmd_next  = cmd_reg;
        sent_next = sent_reg;
        derr_next = derr_reg;

        valid_next = valid_reg && !m_ready;
        type_next  = type_reg;
        pay_next   = pay_reg;
        olen_next  = olen_reg;
        odest_next = odest_reg;
        osrc_next  = osrc_reg;
        oport_next = oport_reg;
        ocmd_next  = ocmd_reg;
        ostat_next = ostat_reg;

        // A terminator or a full buffer closes the frame and restarts from a clean state.
        closing = head_tag.is_cr || (pos_reg >= POS_W'(MAX_FRAME_CHARS));
        payload = 1'b0;
        if (closing) begin
            b_pos = '0; b_sum = '0; b_hn = '0; b_len = '0; b_dest = '0;
            b_src = '0; b_port = '0; b_cmd = '0; b_sent = '0; b_derr = 1'b0;
        end else begin
            b_pos = pos_reg; b_sum = sum_reg; b_hn = hn_reg; b_len = len_reg;
            b_dest = dest_reg; b_src = src_reg; b_port = port_reg;
            b_cmd = cmd_reg; b_sent = sent_reg; b_derr = derr_reg;
        end
        p_plus1   = {1'b0, b_pos} + 9'd1;
        p_plus2   = {1'b0, b_pos} + 9'd2;
        len9      = {1'b0, b_len};
        valid_len = (b_len >= FRAME_OVERHEAD);
        pair      = {b_hn, head_tag.nibble};

        if (pop) begin
            pos_next = b_pos; sum_next = b_sum; hn_next = b_hn; len_next = b_len;
            dest_next = b_dest; src_next = b_src; port_next = b_port;
            cmd_next = b_cmd; sent_next = b_sent; derr_next = b_derr;

            if (!head_tag.is_cr) begin
                if (b_pos < POS_W'(2) || p_plus2 < len9) begin
                    sum_next = b_sum + head_tag.data;
                end
                if (b_pos < HEADER_CHARS) begin
                    derr_next = b_derr || !head_tag.hex_ok;
                    if (!b_pos[0]) begin
                        hn_next = head_tag.nibble;
                    end else begin
                        case (b_pos[3:1])
                            FLD_LENGTH: len_next  = pair;
                            FLD_DEST:   dest_next = pair;
                            FLD_SOURCE: src_next  = pair;
                            FLD_PORT:   port_next = pair;
                            default:    cmd_next  = pair;
                        endcase
                    end
                end else if (valid_len && p_plus2 == len9) begin
                    derr_next = b_derr || !head_tag.hex_ok;
                    hn_next   = head_tag.nibble;
                end else if (valid_len && p_plus1 == len9) begin
                    derr_next = b_derr || !head_tag.hex_ok;
                    sent_next = pair;
                end else if (valid_len && p_plus2 < len9) begin
                    payload = 1'b1;
                end
                pos_next = b_pos + POS_W'(1);
            end

            valid_next = closing || payload;
            if (closing) begin
                type_next  = REC_END;
                pay_next   = 8'd0;
                olen_next  = len_reg;
                odest_next = dest_reg;
                osrc_next  = src_reg;
                oport_next = port_reg;
                ocmd_next  = cmd_reg;
                ostat_next = status;
            end else if (payload) begin
                type_next  = REC_PAYLOAD;
                pay_next   = head_tag.data;
                olen_next  = 8'd0;
                odest_next = 8'd0;
                osrc_next  = 8'd0;
                oport_next = 8'd0;
                ocmd_next  = 8'd0;
                ostat_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= 8'd0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            hn_reg       <= '0;
            len_reg      <= '0;
            dest_reg     <= '0;
            src_reg      <= '0;
            port_reg     <= '0;
            cmd_reg      <= '0;
            sent_reg     <= '0;
            derr_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dev_addr_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            hn_reg    <= hn_next;
            len_reg   <= len_next;
            dest_reg  <= dest_next;
            src_reg   <= src_next;
            port_reg  <= port_next;
            cmd_reg   <= cmd_next;
            sent_reg  <= sent_next;
            derr_reg  <= derr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg  <= type_next;
        pay_reg   <= pay_next;
        olen_reg  <= olen_next;
        odest_reg <= odest_next;
        osrc_reg  <= osrc_next;
        oport_reg <= oport_next;
        ocmd_reg  <= ocmd_next;
        ostat_reg <= ostat_next;
    end

    assign m_valid          = valid_reg;
    assign m_record_type    = type_reg;
    assign m_payload_byte   = pay_reg;
    assign m_frame_length   = olen_reg;
    assign m_dest_address   = odest_reg;
    assign m_source_address = osrc_reg;
    assign m_port_number    = oport_reg;
    assign m_command_code   = ocmd_reg;
    assign m_frame_status   = ostat_reg;

endmodule

>>> hdl/ascii_hex_frame_receiver.sv
// Top level of the ASCII hex frame receiver: front end, word queue, back end.
// Depends on ahfr_pkg, ahfr_front, ahfr_queue and ahfr_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_valid / s_ready  | s_data_byte
//  m_       | out       | m_valid / m_ready  | record type, payload, header, status
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (device address)
//
// Sustained rate is one word per cycle; the back end retires one queued word
// per cycle whenever the result register is free or being taken.
// An accepted word is first written into the queue; the back end then pops it and
// steps its result into the result register that drives m_.
// s_ready drops only while the four-entry queue is full; reset is synchronous,
// active low, and clears the queue, the frame state and the device address.
`timescale 1ns / 1ps

module ascii_hex_frame_receiver
    import ahfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_record_type,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_dest_address,
    output logic [7:0] m_source_address,
    output logic [7:0] m_port_number,
    output logic [7:0] m_command_code,
    output logic [2:0] m_frame_status
);

    tag_t push_tag;
    tag_t head_tag;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    // Classify each incoming word; hold it off while the queue is full.
    ahfr_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_tag    (push_tag)
    );

    // Decouple the input side from output stalls.
    ahfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tag (push_tag),
        .pop      (pop),
        .head_tag (head_tag),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Advance the frame state one word at a time and drive the result register.
    ahfr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .head_tag         (head_tag),
        .queue_empty      (queue_empty),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_type    (m_record_type),
        .m_payload_byte   (m_payload_byte),
        .m_frame_length   (m_frame_length),
        .m_dest_address   (m_dest_address),
        .m_source_address (m_source_address),
        .m_port_number    (m_port_number),
        .m_command_code   (m_command_code),
        .m_frame_status   (m_frame_status)
    );

endmodule

>>> hdl/ahfr_checker.sv
// Port-level checks of the ASCII hex frame receiver, bound to the top level.
// Depends on ahfr_pkg and ascii_hex_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`include "ascii_hex_frame_receiver_defines.svh"

module ahfr_checker
    import ahfr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_record_type,
    input logic [7:0] m_payload_byte,
    input logic [7:0] m_frame_length,
    input logic [7:0] m_dest_address,
    input logic [2:0] m_frame_status
);

    `AHFR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload_byte) && $stable(m_frame_status), "result word changed while stalled")

    `AHFR_ASSERT_NOW(a_payload_clean, m_valid && m_record_type == REC_PAYLOAD, m_frame_status == STATUS_OK && m_frame_length == 8'd0 && m_dest_address == 8'd0, "payload word carries header fields")

    `AHFR_ASSERT_NOW(a_record_clean, m_valid && m_record_type == REC_END, m_payload_byte == 8'd0 && m_frame_status <= STATUS_BAD_DIGIT, "bad end-of-frame record")

    `AHFR_ASSERT_NOW(a_length_ok, m_valid && m_record_type == REC_END && m_frame_status != STATUS_LENGTH, m_frame_length >= FRAME_OVERHEAD, "short frame passed length check")

endmodule

bind ascii_hex_frame_receiver ahfr_checker u_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the ASCII hex frame receiver: directed frames, then random frames.
// Depends on ahfr_pkg and ascii_hex_frame_receiver; an in-bench deframer predicts every result not typed by a row.
`timescale 1ns / 1ps

module tb;
    import ahfr_pkg::*;

    // Cycles to let pass after the last owed result before touching the address register:
    // room for the result register plus a full four-word queue, with margin.
    localparam int DRAIN_PAD  = 12;
    localparam int PHASE_WORDS = 165;

    // One result word as it appears on the m_ channel.
    typedef struct packed {
        logic       rtype;
        logic [7:0] payload;
        logic [7:0] len;
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] port;
        logic [7:0] cmd;
        logic [2:0] status;
    } rec_t;

    // One row of the directed table: a character and, where it is obvious, its result.
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        rec_t       want;
    } script_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_record_type;
    logic [7:0] m_payload_byte;
    logic [7:0] m_frame_length;
    logic [7:0] m_dest_address;
    logic [7:0] m_source_address;
    logic [7:0] m_port_number;
    logic [7:0] m_command_code;
    logic [2:0] m_frame_status;

    ascii_hex_frame_receiver uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_type   (m_record_type),
        .m_payload_byte  (m_payload_byte),
        .m_frame_length  (m_frame_length),
        .m_dest_address  (m_dest_address),
        .m_source_address(m_source_address),
        .m_port_number   (m_port_number),
        .m_command_code  (m_command_code),
        .m_frame_status  (m_frame_status)
    );

    // Deframer state mirrored in the bench, plus the address the bench last wrote.
    logic [7:0] dev_addr;
    logic [7:0] pr_pos, pr_sum, pr_len, pr_dst, pr_src, pr_prt, pr_cmd, pr_chk;
    logic [3:0] pr_hi;
    logic       pr_digit_bad;

    rec_t        owed_results[$];
    script_row_t script[$];
    logic [7:0]  frame_chars[$];

    int gap_in_pct;
    int gap_out_pct;
    int err_count;
    int words_in;
    int results_seen;
    int records_seen;
    int status_seen[5];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------

    function automatic void clear_frame();
        pr_pos = 8'd0; pr_sum = 8'd0; pr_hi = 4'd0;
        pr_len = 8'd0; pr_dst = 8'd0; pr_src = 8'd0;
        pr_prt = 8'd0; pr_cmd = 8'd0; pr_chk = 8'd0;
        pr_digit_bad = 1'b0;
    endfunction

    // Decode one hex digit; anything else reads as zero and marks the frame.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            pr_digit_bad = 1'b1;
        end
        return d[3:0];
    endfunction

    // Place one non-terminator character; return 1 when it is a payload character.
    function automatic bit take_char(input logic [7:0] c);
        int         p;
        int         lf;
        bit         pay;
        bit         len_ok;
        logic [3:0] v;
        p      = int'(pr_pos);
        lf     = int'(pr_len);
        pay    = 1'b0;
        len_ok = (pr_len >= FRAME_OVERHEAD);
        // Sum the header, the payload, and the first two characters in any case.
        if (p < 2 || p + 2 < lf) pr_sum = pr_sum + c;
        if (p < HEADER_CHARS) begin
            v = hex_nibble(c);
            if (p % 2 == 0) begin
                pr_hi = v;
            end else begin
                case (p / 2)
                    FLD_LENGTH: pr_len = {pr_hi, v};
                    FLD_DEST:   pr_dst = {pr_hi, v};
                    FLD_SOURCE: pr_src = {pr_hi, v};
                    FLD_PORT:   pr_prt = {pr_hi, v};
                    default:    pr_cmd = {pr_hi, v};
                endcase
            end
        end else if (len_ok && p + 2 == lf) begin
            pr_hi = hex_nibble(c);
        end else if (len_ok && p + 1 == lf) begin
            v = hex_nibble(c);
            pr_chk = {pr_hi, v};
        end else if (len_ok && p + 2 < lf) begin
            pay = 1'b1;
        end
        pr_pos = pr_pos + 8'd1;
        return pay;
    endfunction

    // Build the end-of-frame record; length beats digit errors beats address beats sum.
    function automatic rec_t close_record();
        rec_t r;
        r = '0;
        r.rtype = REC_END;
        r.len   = pr_len;
        r.dest  = pr_dst;
        r.src   = pr_src;
        r.port  = pr_prt;
        r.cmd   = pr_cmd;
        if (pr_len < FRAME_OVERHEAD || pr_pos != pr_len) begin
            r.status = STATUS_LENGTH;
        end else if (pr_digit_bad) begin
            r.status = STATUS_BAD_DIGIT;
        end else if (pr_dst != dev_addr) begin
            r.status = STATUS_OTHER;
        end else if (pr_sum != pr_chk) begin
            r.status = STATUS_CHECKSUM;
        end else begin
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    task automatic deframe_step(input logic [7:0] c, output bit got, output rec_t r);
        r   = '0;
        got = 1'b1;
        if (c == CHAR_CR) begin
            r = close_record();
            clear_frame();
        end else if (pr_pos >= MAX_FRAME_CHARS) begin
            // Buffer full: close the frame and start the next one with this character.
            r = close_record();
            clear_frame();
            void'(take_char(c));
        end else if (take_char(c)) begin
            r.rtype   = REC_PAYLOAD;
            r.payload = c;
            r.status  = STATUS_OK;
        end else begin
            got = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then log what it owes.
    // A typed row supplies its own expectation in place of the prediction.
    task automatic send_word(input logic [7:0] c, input bit typed, input rec_t want);
        bit   got;
        rec_t res;
        while ($urandom_range(0, 99) < gap_in_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= c;
        do @(posedge aclk); while (!s_ready);
        words_in++;
        deframe_step(c, got, res);
        if (typed) begin
            owed_results.push_back(want);
        end else if (got) begin
            owed_results.push_back(res);
        end
    endtask

    // Drop valid and wait until every owed result has arrived and the pipe is quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_address(input logic [7:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dev_addr = a;
    endtask

    task automatic add_text(input string s);
        script_row_t row;
        row.typed = 1'b0;
        row.want  = '0;
        for (int i = 0; i < s.len(); i++) begin
            row.ch = s[i];
            script.push_back(row);
        end
    endtask

    task automatic add_typed(input logic [7:0] c, input rec_t want);
        script_row_t row;
        row.ch    = c;
        row.typed = 1'b1;
        row.want  = want;
        script.push_back(row);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + n;
        return (lower ? 8'h57 : 8'h37) + n;
    endfunction

    // Append a byte as two hex digits, each in a random case.
    function automatic void push_hex(input logic [7:0] v);
        frame_chars.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
        frame_chars.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
    endfunction

    // Send one frame with random content; most are well formed, the rest carry one flaw:
    // wrong checksum, wrong length field, a bad digit, an oversized body, or no terminator.
    task automatic send_random_frame();
        int         kind;
        int         n_pay;
        int         at;
        logic [7:0] fld[5];
        logic [7:0] sum;
        logic [7:0] b;
        rec_t       none;
        none = '0;
        frame_chars.delete();
        kind  = $urandom_range(0, 99);
        n_pay = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        if (kind >= 86 && kind < 92) n_pay = MAX_FRAME_CHARS - 12;
        if (kind >= 92 && kind < 96) n_pay = MAX_FRAME_CHARS - 12 + $urandom_range(0, 3);
        fld[0] = 8'(12 + n_pay);
        if (kind >= 70 && kind < 78) begin
            if ($urandom_range(0, 2) == 0) fld[0] = 8'($urandom_range(0, 11));
            else fld[0] = fld[0] + ($urandom_range(0, 1) ? 8'd1 : 8'hFF);
        end
        if (kind >= 92 && kind < 96) fld[0] = 8'($urandom_range(MAX_FRAME_CHARS + 1, 255));
        fld[1] = ($urandom_range(0, 99) < 60) ? dev_addr : 8'($urandom_range(0, 255));
        fld[2] = 8'($urandom_range(0, 255));
        fld[3] = 8'($urandom_range(0, 255));
        fld[4] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 5; i++) push_hex(fld[i]);
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom_range(0, 255));
            // Keep the terminator out of the body except in run-on frames.
            if (b == CHAR_CR && kind < 96) b = 8'h0C;
            frame_chars.push_back(b);
        end
        sum = 8'd0;
        foreach (frame_chars[k]) sum = sum + frame_chars[k];
        if (kind >= 60 && kind < 70) sum = sum + 8'($urandom_range(1, 255));
        push_hex(sum);
        if (kind >= 78 && kind < 86) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                       (b >= 8'h61 && b <= 8'h66) || b == CHAR_CR);
            if ($urandom_range(0, 3) == 0) at = frame_chars.size() - 1 - $urandom_range(0, 1);
            else at = $urandom_range(0, 9);
            frame_chars[at] = b;
        end
        if (kind < 96) frame_chars.push_back(CHAR_CR);
        foreach (frame_chars[k]) send_word(frame_chars[k], 1'b0, none);
    endtask

    // Send line noise; a long run without terminator forces the buffer-full close.
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        rec_t       none;
        none = '0;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_FRAME_CHARS, MAX_FRAME_CHARS + 12)
                                        : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (n > 6 && b == CHAR_CR) b = 8'h00;
            send_word(b, 1'b0, none);
        end
        if ($urandom_range(0, 1)) send_word(CHAR_CR, 1'b0, none);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic check_result_word();
        rec_t seen;
        rec_t want;
        seen = '{m_record_type, m_payload_byte, m_frame_length, m_dest_address,
                 m_source_address, m_port_number, m_command_code, m_frame_status};
        results_seen++;
        if (seen.rtype === REC_END) begin
            records_seen++;
            if (seen.status < 5) status_seen[seen.status]++;
        end
        if (owed_results.size() == 0) begin
            flag_error($sformatf("result word with nothing owed: %h", seen));
            return;
        end
        want = owed_results.pop_front();
        if (seen !== want) begin
            flag_error($sformatf({"result %0d: got t%0h p%02h l%02h d%02h s%02h n%02h c%02h",
                                  " st%0d, want t%0h p%02h l%02h d%02h s%02h n%02h c%02h st%0d"},
                                 results_seen, seen.rtype, seen.payload, seen.len, seen.dest,
                                 seen.src, seen.port, seen.cmd, seen.status, want.rtype,
                                 want.payload, want.len, want.dest, want.src, want.port,
                                 want.cmd, want.status));
        end
    endtask

    // Take result words; twice in the run hold ready low long enough to back up the queue
    // and stall the input while the sender keeps offering.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result_word();
                if (results_seen == 40 || results_seen == 250) hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= gap_out_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int target;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_valid     = 1'b0;
        s_data_byte = 8'd0;
        err_count    = 0;
        words_in     = 0;
        results_seen = 0;
        records_seen = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        gap_in_pct  = 33;
        gap_out_pct = 76;
        dev_addr    = 8'd0;
        clear_frame();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_address(8'h00);

        // Terminator straight after reset: empty frame, everything zero, length mismatch.
        add_typed(CHAR_CR, '{REC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, STATUS_LENGTH});
        // Shortest legal frame, mixed-case digits, extreme field values, correct sum.
        add_text("0C00FFffA5A1");
        add_typed(CHAR_CR, '{REC_END, 8'h00, 8'h0C, 8'h00, 8'hFF, 8'hFF, 8'hA5, STATUS_OK});
        // One all-ones payload character, then non-hex checksum digits.
        add_text("0D01020304");
        add_typed(8'hFF, '{REC_PAYLOAD, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, STATUS_OK});
        add_text("zz");
        add_typed(CHAR_CR, '{REC_END, 8'h00, 8'h0D, 8'h01, 8'h02, 8'h03, 8'h04,
                             STATUS_BAD_DIGIT});
        // Zero byte as a lone bad digit: the short frame still reports a length mismatch.
        add_text("");
        script.push_back('{8'h00, 1'b0, '0});
        add_typed(CHAR_CR, '{REC_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, STATUS_LENGTH});
        foreach (script[k]) send_word(script[k].ch, script[k].typed, script[k].want);
        drain();

        // Three random phases with different idling and a fresh device address each.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    gap_in_pct  = 33;
                    gap_out_pct = 76;
                    write_address(8'hFF);
                end
                1: begin
                    gap_in_pct  = 76;
                    gap_out_pct = 33;
                    write_address(8'($urandom_range(1, 254)));
                end
                default: begin
                    gap_in_pct  = 0;
                    gap_out_pct = 0;
                    write_address(8'h00);
                end
            endcase
            target = words_in + PHASE_WORDS;
            while (words_in < target) begin
                if ($urandom_range(0, 99) < 82) send_random_frame();
                else send_noise();
            end
            // Close any open frame so the address change lands between frames.
            send_word(CHAR_CR, 1'b0, '0);
            drain();
        end

        if (owed_results.size() != 0) flag_error("results still owed at end of run");
        $display("Run covered %0d words in and %0d result words out, %0d of them frame records.",
                 words_in, results_seen, records_seen);
        $display({"Record status mix: ok %0d, other address %0d, checksum %0d,",
                  " length %0d, digit %0d."},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
